@@ rtl/smx_pkg.sv @@
package smx_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DEPTH_W     = 7;

  localparam logic [CMD_W-1:0] OP_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] OP_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] OP_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] OP_DIV  = 3'd3;
  localparam logic [CMD_W-1:0] OP_OUT  = 3'd4;
  localparam logic [CMD_W-1:0] OP_HALT = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd5;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } smx_wr_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } smx_div_req_t;

endpackage

@@ rtl/smx_if.sv @@
interface smx_cmd_if import smx_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] operand;

  modport source (output valid, command, operand, input ready);
  modport sink   (input valid, command, operand, output ready);
endinterface

interface smx_res_if import smx_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     value_valid;
  logic [STATUS_W-1:0]      status;
  logic [DEPTH_W-1:0]       depth_now;

  modport source (output valid, value, value_valid, status, depth_now, input ready);
  modport sink   (input valid, value, value_valid, status, depth_now, output ready);
endinterface

@@ rtl/smx_stack_ram.sv @@
module smx_stack_ram import smx_pkg::*; (
  input  logic              clk_i,
  input  smx_wr_t           wr_i,
  input  logic [ADDR_W-1:0] rd_addr_a_i,
  input  logic [ADDR_W-1:0] rd_addr_b_i,
  output logic [DATA_W-1:0] rd_data_a_o,
  output logic [DATA_W-1:0] rd_data_b_o
);

  logic [DATA_W-1:0] mem_q [STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule

@@ rtl/smx_div.sv @@
module smx_div import smx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smx_div_req_t      req_i,
  output logic              busy_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W:0]   rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              sn, tn;

  assign sn = req_i.dividend[DATA_W-1];
  assign tn = req_i.divisor[DATA_W-1];
  assign rem_sh = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = sn ? (DATA_W'(0) - req_i.dividend) : req_i.dividend;
      dvs_d  = tn ? (DATA_W'(0) - req_i.divisor) : req_i.divisor;
      neg_d  = sn ^ tn;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff;
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

@@ rtl/stack_machine_executor.sv @@
// channel  | dir | modport | payload
// cmd_i    | in  | sink    | command[2:0], operand[31:0]
// res_o    | out | source  | value[31:0], value_valid, status[2:0], depth_now[6:0]
//
// Every request first reads the two top entries from the stack RAM, then computes
// the result and writes it back. Division first runs in the restoring divider
// (one quotient bit per cycle) and then writes the quotient back.
// Reset clears the stack count, the halt flag and the result valid flag; the RAM
// is not cleared. A stalled result holds completion of the next request but not its
// acceptance.
module stack_machine_executor import smx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  smx_cmd_if.sink   cmd_i,
  smx_res_if.source res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic                halted_q, halted_d;
  logic [CMD_W-1:0]    cmd_q;
  logic [DATA_W-1:0]   opnd_q;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   value_q, value_d;
  logic                vv_q, vv_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DEPTH_W-1:0]  depth_q, depth_d;

  logic                accept;
  logic                out_free;
  logic                finish;
  logic [DATA_W-1:0]   top_val, sec_val;
  logic [DATA_W-1:0]   quo;
  logic                div_busy;
  smx_wr_t             wr;
  smx_div_req_t        div_req;
  logic [ADDR_W-1:0]   addr_top, addr_sec;

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign addr_top = ADDR_W'(sp_q - SP_W'(1));
  assign addr_sec = ADDR_W'(sp_q - SP_W'(2));

  smx_stack_ram u_ram (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .rd_addr_a_i (addr_top),
    .rd_addr_b_i (addr_sec),
    .rd_data_a_o (top_val),
    .rd_data_b_o (sec_val)
  );

  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  always_comb begin
    state_d          = state_q;
    sp_d             = sp_q;
    halted_d         = halted_q;
    finish           = 1'b0;
    value_d          = '0;
    vv_d             = 1'b0;
    status_d         = ST_OK;
    wr               = '0;
    div_req.start    = 1'b0;
    div_req.dividend = sec_val;
    div_req.divisor  = top_val;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (halted_q) begin
          status_d = ST_HALTED;
        end else begin
          unique case (cmd_q)
            OP_PUSH: begin
              if (sp_q == SP_W'(STACK_DEPTH)) begin
                status_d = ST_OVER;
              end else begin
                wr.en   = 1'b1;
                wr.addr = ADDR_W'(sp_q);
                wr.data = opnd_q;
                sp_d    = sp_q + SP_W'(1);
              end
            end
            OP_ADD, OP_SUB, OP_DIV: begin
              if (sp_q < SP_W'(2)) begin
                status_d = ST_UNDER;
              end else if (cmd_q == OP_DIV) begin
                if (top_val == '0) begin
                  status_d = ST_DIVZERO;
                end else begin
                  div_req.start = 1'b1;
                end
              end else begin
                wr.en   = 1'b1;
                wr.addr = addr_sec;
                wr.data = (cmd_q == OP_ADD) ? (sec_val + top_val) : (sec_val - top_val);
                sp_d    = sp_q - SP_W'(1);
              end
            end
            OP_OUT: begin
              if (sp_q == '0) begin
                status_d = ST_UNDER;
              end else begin
                value_d = top_val;
                vv_d    = 1'b1;
                sp_d    = '0;
              end
            end
            OP_HALT: begin
              halted_d = 1'b1;
            end
            default: begin
              status_d = ST_UNKNOWN;
            end
          endcase
        end
        if (div_req.start) begin
          state_d = S_DIV;
        end else if (out_free) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
        if (!finish) begin
          wr.en    = 1'b0;
          sp_d     = sp_q;
          halted_d = halted_q;
        end
      end
      S_DIV: begin
        if (!div_busy && out_free) begin
          finish  = 1'b1;
          wr.en   = 1'b1;
          wr.addr = addr_sec;
          wr.data = quo;
          sp_d    = sp_q - SP_W'(1);
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    depth_d     = DEPTH_W'(sp_d);
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i.command;
      opnd_q <= cmd_i.operand;
    end
    if (finish) begin
      value_q  <= value_d;
      vv_q     <= vv_d;
      status_q <= status_d;
      depth_q  <= depth_d;
    end
  end

  assign cmd_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.value       = value_q;
  assign res_o.value_valid = vv_q;
  assign res_o.status      = status_q;
  assign res_o.depth_now   = depth_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted request not executed");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag dropped");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_DIV)
    else $error("divider busy outside divide state");

  a_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.value_valid) |-> res_o.status == ST_OK)
    else $error("value reported with error status");

endmodule

@@ bench/stack_machine_executor_tb.sv @@
module stack_machine_executor_tb import smx_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0]  OP_UNDEF_A = 3'd6;
  localparam logic [CMD_W-1:0]  OP_UNDEF_B = 3'd7;
  localparam logic [DATA_W-1:0] MOST_NEG   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam int unsigned       RANDOM_REQS = 1300;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic                value_valid;
    logic [STATUS_W-1:0] status;
    logic [DEPTH_W-1:0]  depth_now;
  } smx_result_t;

  class stack_scoreboard;
    logic [DATA_W-1:0] entries [STACK_DEPTH];
    int unsigned       sp;
    bit                halted;
    smx_result_t       pending_results [$];
    int unsigned       errors;

    function new();
      sp = 0;
      halted = 1'b0;
      errors = 0;
    endfunction

    function int unsigned depth();
      return sp;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // signed divide, truncating toward zero, wrapping at 32 bits
    function logic [DATA_W-1:0] quotient(logic [DATA_W-1:0] s, logic [DATA_W-1:0] t);
      logic [DATA_W-1:0] ms, mt, q;
      ms = s[DATA_W-1] ? -s : s;
      mt = t[DATA_W-1] ? -t : t;
      q = ms / mt;
      return (s[DATA_W-1] ^ t[DATA_W-1]) ? -q : q;
    endfunction

    function void flag_mismatch(string what, smx_result_t exp, smx_result_t got);
      errors++;
      if (errors <= 10) begin
        $display("%0t mismatch (%s): exp value=%h vv=%b st=%0d depth=%0d",
                 $realtime, what, exp.value, exp.value_valid, exp.status, exp.depth_now);
        $display("%0t            got value=%h vv=%b st=%0d depth=%0d",
                 $realtime, got.value, got.value_valid, got.status, got.depth_now);
      end
    endfunction

    function void note_instruction(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] opnd);
      smx_result_t       r;
      logic [DATA_W-1:0] top, sec, acc;
      r = '0;
      r.status = ST_OK;
      if (halted) begin
        r.status = ST_HALTED;
      end else begin
        case (cmd)
          OP_PUSH: begin
            if (sp >= STACK_DEPTH) begin
              r.status = ST_OVER;
            end else begin
              entries[sp] = opnd;
              sp++;
            end
          end
          OP_ADD, OP_SUB, OP_DIV: begin
            if (sp < 2) begin
              r.status = ST_UNDER;
            end else begin
              top = entries[sp-1];
              sec = entries[sp-2];
              if (cmd == OP_DIV && top == '0) begin
                r.status = ST_DIVZERO;
              end else begin
                if (cmd == OP_ADD) acc = sec + top;
                else if (cmd == OP_SUB) acc = sec - top;
                else acc = quotient(sec, top);
                sp--;
                entries[sp-1] = acc;
              end
            end
          end
          OP_OUT: begin
            if (sp == 0) begin
              r.status = ST_UNDER;
            end else begin
              r.value = entries[sp-1];
              r.value_valid = 1'b1;
              sp = 0;
            end
          end
          OP_HALT: begin
            halted = 1'b1;
          end
          default: begin
            r.status = ST_UNKNOWN;
          end
        endcase
      end
      r.depth_now = DEPTH_W'(sp);
      pending_results.push_back(r);
    endfunction

    function void check_result(smx_result_t got);
      smx_result_t exp;
      if (pending_results.size() == 0) begin
        flag_mismatch("no request pending", '0, got);
        return;
      end
      exp = pending_results.pop_front();
      if (got.value !== exp.value || got.value_valid !== exp.value_valid ||
          got.status !== exp.status || got.depth_now !== exp.depth_now)
        flag_mismatch("field", exp, got);
    endfunction

    function void check_drained();
      while (pending_results.size() != 0)
        flag_mismatch("never returned", pending_results.pop_front(), '0);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   tx_burst;
  bit   rx_burst;

  stack_scoreboard sb;

  smx_cmd_if cmd_if ();
  smx_res_if res_if ();

  stack_machine_executor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result('{res_if.value, res_if.value_valid, res_if.status, res_if.depth_now});
  end

  // result side: random back-pressure, two long hold-offs
  initial begin : result_sink
    int unsigned taken, stall;
    res_if.ready <= 1'b0;
    taken = 0;
    rx_burst = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken == 300 || taken == 900) begin
        stall = 400;
      end else begin
        if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
        stall = rx_burst ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      taken++;
    end
  end

  task automatic send_instruction(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] opnd);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= cmd;
    cmd_if.operand <= opnd;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sb.note_instruction(cmd, opnd);
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(0, 1) ? ALL_ONES : 32'd1;
      2: return $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
      3, 4, 5: return DATA_W'($signed($urandom_range(0, 40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int unsigned depth);
    int unsigned r;
    logic [CMD_W-1:0] c;
    r = $urandom_range(0, 99);
    if (depth < 2) begin
      if (r < 70) return OP_PUSH;
      if (r < 85) return CMD_W'($urandom_range(OP_ADD, OP_DIV));
      if (r < 95) return OP_OUT;
      return $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
    end
    if (r < 35) return OP_PUSH;
    if (r < 50) return OP_ADD;
    if (r < 65) return OP_SUB;
    if (r < 80) return OP_DIV;
    if (r < 92) return OP_OUT;
    if (r < 96) return $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
    // noise, halt is held back for the end
    c = CMD_W'($urandom_range(0, 7));
    return (c == OP_HALT) ? OP_UNDEF_A : c;
  endfunction

  initial begin : request_source
    int unsigned fill_left;
    logic [CMD_W-1:0] cmd;
    sb = new();
    tx_burst = 1'b0;
    rst_ni = 1'b0;
    cmd_if.valid   <= 1'b0;
    cmd_if.command <= OP_PUSH;
    cmd_if.operand <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty stack, unknown opcodes
    send_instruction(OP_ADD, '0);
    send_instruction(OP_SUB, '0);
    send_instruction(OP_DIV, '0);
    send_instruction(OP_OUT, '0);
    send_instruction(OP_UNDEF_A, ALL_ONES);
    send_instruction(OP_UNDEF_B, MOST_NEG);
    // wrap on add, most negative by -1, divide by zero
    send_instruction(OP_PUSH, MOST_POS);
    send_instruction(OP_PUSH, 32'd1);
    send_instruction(OP_ADD, ALL_ONES);
    send_instruction(OP_PUSH, ALL_ONES);
    send_instruction(OP_DIV, '0);
    send_instruction(OP_PUSH, '0);
    send_instruction(OP_DIV, '0);
    send_instruction(OP_SUB, '0);
    // truncation toward zero
    send_instruction(OP_PUSH, -32'sd7);
    send_instruction(OP_PUSH, 32'd2);
    send_instruction(OP_DIV, '0);
    send_instruction(OP_SUB, '0);
    send_instruction(OP_OUT, '0);
    send_instruction(OP_OUT, '0);
    send_instruction(OP_PUSH, 32'h5555_5555);
    send_instruction(OP_PUSH, 32'hAAAA_AAAA);
    send_instruction(OP_SUB, '0);
    send_instruction(OP_OUT, '0);

    fill_left = 0;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      // now and then run the stack up to full and past it
      if (fill_left == 0 && $urandom_range(0, 99) < 3)
        fill_left = STACK_DEPTH - sb.depth() + $urandom_range(1, 4);
      if (fill_left > 0) begin
        cmd = OP_PUSH;
        fill_left--;
      end else begin
        cmd = pick_command(sb.depth());
      end
      send_instruction(cmd, (cmd == OP_PUSH) ? pick_operand() : DATA_W'($urandom));
    end

    // halt with a non-empty stack, then everything is ignored
    send_instruction(OP_PUSH, 32'd7);
    send_instruction(OP_PUSH, 32'd9);
    send_instruction(OP_HALT, '0);
    send_instruction(OP_PUSH, 32'd1);
    send_instruction(OP_ADD, '0);
    send_instruction(OP_OUT, '0);
    send_instruction(OP_HALT, '0);
    send_instruction(OP_UNDEF_B, ALL_ONES);
    cmd_if.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    sb.check_drained();
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
